FILE: src/srcs_pkg.sv
// Shared types, constants and decode helpers for the six-register step processor.
// Used by srcs_alu and six_register_cpu_step; depends on nothing else.
package srcs_pkg;

    localparam int PROG_DEPTH = 64;
    localparam int PROG_AW    = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;

    localparam int NUM_REGS  = 6;
    localparam int MAX_REG   = 5;
    localparam int WORD_W    = 64;
    localparam int IMM_W     = 32;
    localparam int RIDX_W    = 3;
    localparam int OPC_W     = 4;
    localparam int KIND_W    = 2;
    localparam int LEN_W     = 7;
    localparam int STEP_W    = 63;
    localparam int ADDR_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    // Effective program length cap: the smaller of the store depth and the length range
    localparam int LEN_CAP = (PROG_DEPTH < (2 ** LEN_W) - 1) ? PROG_DEPTH : (2 ** LEN_W) - 1;

    localparam int IN_W        = ADDR_W + OPC_W + 2 * IMM_W + RIDX_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = ADDR_W + NUM_REGS * WORD_W + STEP_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD,
        KIND_STEP,
        KIND_CLEAR,
        KIND_NONE
    } kind_t;

    typedef enum logic [OPC_W-1:0] {
        OP_ADDR, OP_ADDI, OP_MULR, OP_MULI,
        OP_BANR, OP_BANI, OP_BORR, OP_BORI,
        OP_SETR, OP_SETI, OP_GTIR, OP_GTRI,
        OP_GTRR, OP_EQIR, OP_EQRI, OP_EQRR
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINTER,
        CFG_LENGTH
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MP_LO,
        MP_CROSS_A,
        MP_CROSS_B
    } mul_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_OPB,
        ST_MUL_LO,
        ST_MUL_XA,
        ST_EXEC,
        ST_ADVANCE,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t        op;
        mul_phase_t phase;
    } alu_req_t;

    typedef struct packed {
        logic a_is_reg;
        logic b_is_reg;
    } src_kind_t;

    // One program word: control bits above the two operands
    typedef struct packed {
        logic [RIDX_W-1:0] target;
        op_t               opcode;
        logic [IMM_W-1:0]  operand_b;
        logic [IMM_W-1:0]  operand_a;
    } prog_word_t;

    typedef struct packed {
        logic [RIDX_W-1:0] target;
        logic [IMM_W-1:0]  operand_b;
        logic [IMM_W-1:0]  operand_a;
        op_t               opcode;
        logic [ADDR_W-1:0] load_address;
    } in_item_t;

    typedef struct packed {
        logic [STEP_W-1:0]                  steps_done;
        logic [NUM_REGS-1:0][WORD_W-1:0]    regs;
        logic [ADDR_W-1:0]                  executed_address;
    } out_item_t;

    function automatic src_kind_t src_kind(op_t op);
        src_kind_t sk;
        case (op) inside
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR:
                sk = '{a_is_reg: 1'b1, b_is_reg: 1'b1};
            OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR, OP_GTRI, OP_EQRI:
                sk = '{a_is_reg: 1'b1, b_is_reg: 1'b0};
            OP_GTIR, OP_EQIR:
                sk = '{a_is_reg: 1'b0, b_is_reg: 1'b1};
            default:
                sk = '{a_is_reg: 1'b0, b_is_reg: 1'b0};
        endcase
        return sk;
    endfunction

    function automatic logic is_mul(op_t op);
        return (op == OP_MULR) || (op == OP_MULI);
    endfunction

    function automatic logic [WORD_W-1:0] sext_imm(logic [IMM_W-1:0] v);
        return {{(WORD_W - IMM_W){v[IMM_W-1]}}, v};
    endfunction

endpackage

FILE: src/six_register_cpu_step.sv
// Six-register step processor: sequencer, register file, program store and output stage.
// Depends on srcs_pkg and srcs_alu.
// Sequence: a step runs fetch, decode, operand B, execute, advance and done (a multiply adds
// two multiplier states and so makes three passes through the shared 32x32 multiplier); a
// halting step goes from fetch to done; a program write, a clear or an unknown kind goes
// straight to done. One item is in work at a time. The result waits in an output register.
// Reset (rst_n low, asynchronous) zeroes registers, step count, pointer select and length;
// the program store is not cleared.
module six_register_cpu_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // load_address, opcode, operand_a, operand_b, target, zero pad
    input  logic [srcs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic [srcs_pkg::KIND_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // executed_address, reg_zero .. reg_five, steps_done, zero pad
    output logic [srcs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // halted, invalid
    output logic [srcs_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                cfg_we,
    input  logic [srcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srcs_pkg::CFG_W-1:0]          cfg_data
);
    import srcs_pkg::*;

    state_t             state_reg, state_next;
    logic [WORD_W-1:0]  regs_reg [NUM_REGS];
    logic [WORD_W-1:0]  regs_next [NUM_REGS];
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [RIDX_W-1:0]  ptr_reg, ptr_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               m_tvalid_reg, m_tvalid_next;

    prog_word_t         instr_reg, instr_next;
    logic               bad_reg, bad_next;
    logic               halted_reg, halted_next;
    logic [PROG_AW-1:0] ip_reg, ip_next;
    logic [WORD_W-1:0]  x_reg, x_next;
    logic [WORD_W-1:0]  y_reg, y_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    out_item_t          out_item_reg, out_item_next;
    logic               out_halted_reg, out_halted_next;
    logic               out_invalid_reg, out_invalid_next;

    prog_word_t         prog_mem [PROG_DEPTH];
    prog_word_t         prog_rd_reg;
    logic [PROG_AW-1:0] mem_raddr;
    logic               mem_we;

    in_item_t           in_item;
    kind_t              kind;
    logic               accept;

    logic [RIDX_W-1:0]  rf_raddr;
    logic               rf_ok;
    logic [WORD_W-1:0]  rf_rd;
    logic [LEN_W-1:0]   len_eff;
    logic               ip_fits;
    logic               a_ok;
    logic               b_ok;
    src_kind_t          dec_sk;
    src_kind_t          exe_sk;

    alu_req_t           alu_req;
    logic [WORD_W-1:0]  alu_res;

    assign in_item  = in_item_t'(s_tdata[IN_W-1:0]);
    assign kind     = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_item_reg};
    assign m_tuser  = {out_invalid_reg, out_halted_reg};

    // Register operand checks; negative values are out of range as unsigned
    assign a_ok   = (prog_rd_reg.operand_a <= IMM_W'(MAX_REG));
    assign b_ok   = (instr_reg.operand_b <= IMM_W'(MAX_REG));
    assign dec_sk = src_kind(prog_rd_reg.opcode);
    assign exe_sk = src_kind(instr_reg.opcode);

    // Single addressed register-file read port, address chosen by the sequencer (done copies all registers)
    always_comb
    begin
        case (state_reg)
            ST_DECODE:
            begin
                rf_raddr = prog_rd_reg.operand_a[RIDX_W-1:0];
                rf_ok    = a_ok;
            end
            ST_OPB:
            begin
                rf_raddr = instr_reg.operand_b[RIDX_W-1:0];
                rf_ok    = b_ok;
            end
            default:
            begin
                rf_raddr = ptr_reg;
                rf_ok    = 1'b1;
            end
        endcase
        rf_rd = (rf_ok && (rf_raddr <= RIDX_W'(MAX_REG))) ? regs_reg[rf_raddr] : '0;
    end

    assign len_eff   = (len_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_reg;
    assign ip_fits   = (rf_rd[WORD_W-1:LEN_W] == '0) && (rf_rd[LEN_W-1:0] < len_eff);
    assign mem_raddr = rf_rd[PROG_AW-1:0];
    assign mem_we    = accept && (kind == KIND_LOAD) && (32'(in_item.load_address) < PROG_DEPTH);

    always_comb
    begin
        alu_req.op = instr_reg.opcode;
        case (state_reg)
            ST_MUL_LO: alu_req.phase = MP_LO;
            ST_MUL_XA: alu_req.phase = MP_CROSS_A;
            default:   alu_req.phase = MP_CROSS_B;
        endcase
    end

    srcs_alu u_alu (
        .req (alu_req),
        .x   (x_reg),
        .y   (y_reg),
        .acc (acc_reg),
        .res (alu_res)
    );

    always_comb
    begin
        state_next       = state_reg;
        regs_next        = regs_reg;
        steps_next       = steps_reg;
        ptr_next         = ptr_reg;
        len_next         = len_reg;
        m_tvalid_next    = m_tvalid_reg;
        instr_next       = instr_reg;
        bad_next         = bad_reg;
        halted_next      = halted_reg;
        ip_next          = ip_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        acc_next         = acc_reg;
        out_item_next    = out_item_reg;
        out_halted_next  = out_halted_reg;
        out_invalid_next = out_invalid_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    halted_next = 1'b0;
                    bad_next    = 1'b0;
                    ip_next     = '0;
                    case (kind)
                        KIND_STEP:
                        begin
                            state_next = ST_FETCH;
                        end
                        KIND_CLEAR:
                        begin
                            for (int i = 0; i < NUM_REGS; i++)
                            begin
                                regs_next[i] = '0;
                            end
                            steps_next = '0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (ip_fits)
                begin
                    ip_next    = rf_rd[PROG_AW-1:0];
                    state_next = ST_DECODE;
                end
                else
                begin
                    halted_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DECODE:
            begin
                instr_next = prog_rd_reg;
                bad_next   = (prog_rd_reg.target > RIDX_W'(MAX_REG))
                           || (dec_sk.a_is_reg && !a_ok)
                           || (dec_sk.b_is_reg && !(prog_rd_reg.operand_b <= IMM_W'(MAX_REG)));
                x_next     = dec_sk.a_is_reg ? rf_rd : sext_imm(prog_rd_reg.operand_a);
                state_next = ST_OPB;
            end
            ST_OPB:
            begin
                y_next     = exe_sk.b_is_reg ? rf_rd : sext_imm(instr_reg.operand_b);
                state_next = is_mul(instr_reg.opcode) ? ST_MUL_LO : ST_EXEC;
            end
            ST_MUL_LO:
            begin
                acc_next   = alu_res;
                state_next = ST_MUL_XA;
            end
            ST_MUL_XA:
            begin
                acc_next   = alu_res;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!bad_reg)
                begin
                    regs_next[instr_reg.target] = alu_res;
                end
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE:
            begin
                // advance the pointer after the destination write has landed
                regs_next[ptr_reg] = rf_rd + WORD_W'(1);
                steps_next         = steps_reg + STEP_W'(1);
                state_next         = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    for (int i = 0; i < NUM_REGS; i++)
                    begin
                        out_item_next.regs[i] = regs_reg[i];
                    end
                    out_item_next.steps_done       = steps_reg;
                    out_item_next.executed_address = ADDR_W'(ip_reg);
                    out_halted_next                = halted_reg;
                    out_invalid_next               = bad_reg;
                    m_tvalid_next                  = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POINTER:
                begin
                    // drop pointer selects that name no register
                    if (cfg_data[RIDX_W-1:0] <= RIDX_W'(MAX_REG))
                    begin
                        ptr_next = cfg_data[RIDX_W-1:0];
                    end
                end
                CFG_LENGTH:
                begin
                    len_next = cfg_data[LEN_W-1:0];
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            steps_reg    <= '0;
            ptr_reg      <= '0;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            steps_reg    <= steps_next;
            ptr_reg      <= ptr_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
            regs_reg     <= regs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg       <= instr_next;
        bad_reg         <= bad_next;
        halted_reg      <= halted_next;
        ip_reg          <= ip_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        acc_reg         <= acc_next;
        out_item_reg    <= out_item_next;
        out_halted_reg  <= out_halted_next;
        out_invalid_reg <= out_invalid_next;
    end

    // Program store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prog_mem[PROG_AW'(in_item.load_address)] <= prog_word_t'({in_item.target,
                in_item.opcode, in_item.operand_b, in_item.operand_a});
        end
        prog_rd_reg <= prog_mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= RIDX_W'(MAX_REG))
        else $error("pointer select names no register");

    a_halt_not_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(out_halted_reg && out_invalid_reg))
        else $error("result both halted and invalid");

    a_step_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_STEP)) |=> (state_reg == ST_FETCH))
        else $error("step transfer did not start a fetch");

    a_mul_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_LO) |=> (state_reg == ST_MUL_XA))
        else $error("multiply phases out of order");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADVANCE) |=> (steps_reg == $past(steps_reg) + STEP_W'(1)))
        else $error("step count did not advance by one");
`endif

endmodule

FILE: src/srcs_alu.sv
// Shared arithmetic unit: add, logic, signed compare, and a 32x32 multiplier
// that builds the low 64 bits of a product over three phases. Uses srcs_pkg.
module srcs_alu (
    input  srcs_pkg::alu_req_t            req,
    input  logic [srcs_pkg::WORD_W-1:0]   x,
    input  logic [srcs_pkg::WORD_W-1:0]   y,
    input  logic [srcs_pkg::WORD_W-1:0]   acc,
    output logic [srcs_pkg::WORD_W-1:0]   res
);
    import srcs_pkg::*;

    logic [IMM_W-1:0]   mx;
    logic [IMM_W-1:0]   my;
    logic [WORD_W-1:0]  prod;
    logic [WORD_W-1:0]  cross_part;

    // Low x low first, then each cross term lands in the upper half
    always_comb
    begin
        mx         = (req.phase == MP_CROSS_B) ? x[WORD_W-1:IMM_W] : x[IMM_W-1:0];
        my         = (req.phase == MP_CROSS_A) ? y[WORD_W-1:IMM_W] : y[IMM_W-1:0];
        prod       = WORD_W'(mx) * WORD_W'(my);
        cross_part = {prod[IMM_W-1:0], {IMM_W{1'b0}}};
    end

    always_comb
    begin
        case (req.op) inside
            OP_ADDR, OP_ADDI:
                res = x + y;
            OP_MULR, OP_MULI:
                res = (req.phase == MP_LO) ? prod : acc + cross_part;
            OP_BANR, OP_BANI:
                res = x & y;
            OP_BORR, OP_BORI:
                res = x | y;
            OP_SETR, OP_SETI:
                res = x;
            OP_GTIR, OP_GTRI, OP_GTRR:
                res = {{(WORD_W - 1){1'b0}}, ($signed(x) > $signed(y))};
            OP_EQIR, OP_EQRI, OP_EQRR:
                res = {{(WORD_W - 1){1'b0}}, (x == y)};
            default:
                res = '0;
        endcase
    end

endmodule
